// ===== rtl/hd3d_pkg.sv =====
// Package with shared codes, widths and control structs of the Hausdorff distance block.
`timescale 1ns / 1ps

package hd3d_pkg;

  // Command codes carried on the input tuser.
  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPUTE     = 2'd2;

  // Result distance width and its saturation value.
  localparam int DIST_W = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Output tdata width: the distance filled up to whole bytes.
  localparam int OUT_DW = ((DIST_W + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan_valid;   // a point pair is read this cycle
    logic scan_dir;     // 0: first set is the outer set, 1: second set is
    logic scan_first;   // pair opens a row of the inner scan
    logic scan_last;    // pair closes a row of the inner scan
    logic clear_worst;  // reset the running maximum
    logic sqrt_start;   // start the square root on the running maximum
  } hd3d_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic              pipe_busy;  // distance pipeline still holds pairs
    logic              sqrt_done;  // one-cycle pulse, root is ready
    logic [DIST_W-1:0] distance;   // saturated root
  } hd3d_status_t;

endpackage

// ===== rtl/hd3d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hd3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/hd3d_datapath.sv =====
// Datapath: point stores, squared distance pipeline, min/max tracking and square root.
`timescale 1ns / 1ps

module hd3d_datapath
  import hd3d_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24,
  parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_first,
  input  logic                    wr_second,
  input  logic [AW-1:0]           wr_addr,
  input  logic [3*COORD_BITS-1:0] wr_point,
  input  logic [AW-1:0]           outer_addr,
  input  logic [AW-1:0]           inner_addr,
  input  hd3d_cmd_t               cmd,
  output hd3d_status_t            status
);

  localparam int CB   = COORD_BITS;
  localparam int PW   = 3 * CB;
  localparam int MW   = CB + 1;
  localparam int SW   = 2 * MW;
  localparam int SUMW = SW + 2;
  localparam int HW   = SUMW / 2;
  localparam int RMW  = HW + 2;
  localparam int ICW  = $clog2(HW + 1);
  localparam int EW   = (HW > DIST_W) ? HW : DIST_W;

  // Point stores.
  logic [AW-1:0] first_raddr, second_raddr;
  logic [PW-1:0] first_q, second_q;

  assign first_raddr  = cmd.scan_dir ? inner_addr : outer_addr;
  assign second_raddr = cmd.scan_dir ? outer_addr : inner_addr;

  hd3d_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS), .AW(AW)) u_first_ram (
    .clk     (clk),
    .wr_en   (wr_first),
    .wr_addr (wr_addr),
    .wr_data (wr_point),
    .rd_addr (first_raddr),
    .rd_data (first_q)
  );

  hd3d_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS), .AW(AW)) u_second_ram (
    .clk     (clk),
    .wr_en   (wr_second),
    .wr_addr (wr_addr),
    .wr_data (wr_point),
    .rd_addr (second_raddr),
    .rd_data (second_q)
  );

  // Tags that follow each pair down the pipeline.
  logic v0, v1, v2, v3, row_end;
  logic dir0;
  logic first0, first1, first2, first3;
  logic last0, last1, last2, last3;

  // Read stage: absolute coordinate differences.
  logic [PW-1:0] outer_p, inner_p;
  logic signed [CB:0] dx, dy, dz;

  assign outer_p = dir0 ? second_q : first_q;
  assign inner_p = dir0 ? first_q  : second_q;

  assign dx = $signed({outer_p[CB-1], outer_p[CB-1:0]})
            - $signed({inner_p[CB-1], inner_p[CB-1:0]});
  assign dy = $signed({outer_p[2*CB-1], outer_p[2*CB-1:CB]})
            - $signed({inner_p[2*CB-1], inner_p[2*CB-1:CB]});
  assign dz = $signed({outer_p[3*CB-1], outer_p[3*CB-1:2*CB]})
            - $signed({inner_p[3*CB-1], inner_p[3*CB-1:2*CB]});

  logic [MW-1:0] ax, ay, az;
  logic [SW-1:0] sqx, sqy, sqz;
  logic [SUMW-1:0] dsq, best, worst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      row_end <= 1'b0;
    end else begin
      v0 <= cmd.scan_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      row_end <= v3 & last3;
    end
    dir0   <= cmd.scan_dir;
    first0 <= cmd.scan_first;
    last0  <= cmd.scan_last;
    first1 <= first0;
    last1  <= last0;
    first2 <= first1;
    last2  <= last1;
    first3 <= first2;
    last3  <= last2;

    ax <= dx[CB] ? $unsigned(-dx) : $unsigned(dx);
    ay <= dy[CB] ? $unsigned(-dy) : $unsigned(dy);
    az <= dz[CB] ? $unsigned(-dz) : $unsigned(dz);

    sqx <= SW'(ax) * SW'(ax);
    sqy <= SW'(ay) * SW'(ay);
    sqz <= SW'(az) * SW'(az);

    dsq <= SUMW'(sqx) + SUMW'(sqy) + SUMW'(sqz);

    // Nearest distance within a row; the row start reseeds it.
    if (v3) begin
      if (first3 || (dsq < best)) begin
        best <= dsq;
      end
    end

    // The row minimum is final in the cycle after the row closes, when row_end is high.
    if (cmd.clear_worst) begin
      worst <= '0;
    end else if (row_end && (best > worst)) begin
      worst <= best;
    end
  end

  // Restoring square root, one result bit per cycle.
  logic [SUMW-1:0] sq_val;
  logic [RMW-1:0]  rem, rem_sh, trial;
  logic [HW-1:0]   root;
  logic [ICW-1:0]  iter;
  logic            running, done;
  logic            ge;

  assign rem_sh = {rem[RMW-3:0], sq_val[SUMW-1:SUMW-2]};
  assign trial  = {root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.sqrt_start) begin
        running <= 1'b1;
      end else if (running && (iter == ICW'(1))) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
    if (cmd.sqrt_start) begin
      sq_val <= worst;
      rem    <= '0;
      root   <= '0;
      iter   <= ICW'(HW);
    end else if (running) begin
      sq_val <= {sq_val[SUMW-3:0], 2'b00};
      rem    <= ge ? (rem_sh - trial) : rem_sh;
      root   <= {root[HW-2:0], ge};
      iter   <= iter - ICW'(1);
    end
  end

  logic [EW-1:0] root_ext;
  assign root_ext = EW'(root);

  always_comb begin
    status.pipe_busy = v0 | v1 | v2 | v3 | row_end;
    status.sqrt_done = done;
    status.distance  = (root_ext > EW'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];
  end

endmodule

// ===== rtl/hd3d_ctrl.sv =====
// Controller: load handshake, point counts, pair scan sequencing and result register.
`timescale 1ns / 1ps

module hd3d_ctrl
  import hd3d_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  output logic              wr_first,
  output logic              wr_second,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     outer_addr,
  output logic [AW-1:0]     inner_addr,
  output hd3d_cmd_t         cmd,
  input  hd3d_status_t      status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_distance,
  output logic              out_empty,
  output logic              out_overflowed
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

  typedef enum logic [2:0] {IDLE, SCAN, DRAIN, SQRT, RESULT} state_t;

  state_t        state;
  logic [CW-1:0] first_count, second_count;
  logic          overflow_seen, empty_flag;
  logic          dir;
  logic [AW-1:0] outer_idx, inner_idx;
  logic          clear_worst, sqrt_start;

  logic          accept, load_first, load_second;
  logic [CW-1:0] n_outer, n_inner;
  logic          row_last, outer_last;

  assign in_ready    = (state == IDLE);
  assign accept      = in_valid & in_ready;
  assign load_first  = accept && (in_cmd == CMD_LOAD_FIRST);
  assign load_second = accept && (in_cmd == CMD_LOAD_SECOND);

  assign wr_first  = load_first  && (first_count  != FULL);
  assign wr_second = load_second && (second_count != FULL);
  assign wr_addr   = load_first ? first_count[AW-1:0] : second_count[AW-1:0];

  assign n_outer    = dir ? second_count : first_count;
  assign n_inner    = dir ? first_count  : second_count;
  assign row_last   = (CW'(inner_idx) == n_inner - CW'(1));
  assign outer_last = (CW'(outer_idx) == n_outer - CW'(1));

  assign outer_addr = outer_idx;
  assign inner_addr = inner_idx;

  always_comb begin
    cmd.scan_valid  = (state == SCAN);
    cmd.scan_dir    = dir;
    cmd.scan_first  = (inner_idx == '0);
    cmd.scan_last   = row_last;
    cmd.clear_worst = clear_worst;
    cmd.sqrt_start  = sqrt_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      empty_flag    <= 1'b0;
      dir           <= 1'b0;
      outer_idx     <= '0;
      inner_idx     <= '0;
      clear_worst   <= 1'b0;
      sqrt_start    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      clear_worst <= 1'b0;
      sqrt_start  <= 1'b0;
      if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (wr_first) begin
            first_count <= first_count + CW'(1);
          end
          if (wr_second) begin
            second_count <= second_count + CW'(1);
          end
          if ((load_first && !wr_first) || (load_second && !wr_second)) begin
            overflow_seen <= 1'b1;
          end
          if (accept && (in_cmd == CMD_COMPUTE)) begin
            if ((first_count == '0) || (second_count == '0)) begin
              empty_flag <= 1'b1;
              state      <= RESULT;
            end else begin
              empty_flag  <= 1'b0;
              dir         <= 1'b0;
              outer_idx   <= '0;
              inner_idx   <= '0;
              clear_worst <= 1'b1;
              state       <= SCAN;
            end
          end
        end

        SCAN: begin
          if (!row_last) begin
            inner_idx <= inner_idx + AW'(1);
          end else begin
            inner_idx <= '0;
            if (!outer_last) begin
              outer_idx <= outer_idx + AW'(1);
            end else begin
              outer_idx <= '0;
              if (!dir) begin
                dir <= 1'b1;
              end else begin
                state <= DRAIN;
              end
            end
          end
        end

        DRAIN: begin
          if (!status.pipe_busy) begin
            sqrt_start <= 1'b1;
            state      <= SQRT;
          end
        end

        SQRT: begin
          if (status.sqrt_done) begin
            state <= RESULT;
          end
        end

        RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            out_distance   <= empty_flag ? '0 : status.distance;
            out_empty      <= empty_flag;
            out_overflowed <= overflow_seen;
            first_count    <= '0;
            second_count   <= '0;
            overflow_seen  <= 1'b0;
            state          <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/hausdorff_distance_3d_top.sv =====
// Top level of the symmetric 3D Hausdorff distance block.
`timescale 1ns / 1ps

// Usage: points stream in on the slave channel, one per transaction. The command
// code on s_axis_tuser selects the target: load into the first set, load into the
// second set, or compute. A load does not stall the channel: the block takes the next
// transaction in the following cycle. A load into a full set is dropped and
// remembered as an overflow; an unused command code is consumed and ignored.
// A compute transaction stalls the slave channel while the block scans every
// point pair in both directions, one pair per cycle through the RAM read port
// and distance pipeline. m_axis_tvalid rises after the scan itself, the drain of
// the pipeline, the bit-serial square root with its start and handoff, and the
// load of the result register. With either set empty, the block skips the scan
// and the square root and goes straight to the result register, with a zero
// distance.
// One result transaction leaves on the master channel per compute; both sets
// and the overflow flag are then cleared. The result register holds while the
// receiver stalls, and loads are still taken while a result waits; a second
// compute waits only at its end for the register to free up.
// Reset (synchronous, active high) empties both sets and clears the flags;
// the point RAMs are not cleared since only entries below the fill counts are read.

module hausdorff_distance_3d_top
  import hd3d_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic clk,
  input  logic rst,

  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0 up: coord_x, coord_y, coord_z, zero fill.
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Fields from bit 0 up: cmd.
  input  logic [1:0]                            s_axis_tuser,

  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Fields from bit 0 up: distance, zero fill.
  output logic [OUT_DW-1:0]                     m_axis_tdata,
  // Fields from bit 0 up: empty_set, overflowed.
  output logic [1:0]                            m_axis_tuser
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  hd3d_cmd_t         cmd;
  hd3d_status_t      status;
  logic              wr_first, wr_second;
  logic [AW-1:0]     wr_addr, outer_addr, inner_addr;
  logic [DIST_W-1:0] distance;
  logic              empty_set, overflowed;

  // The controller owns the handshakes and sequencing.
  hd3d_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_cmd         (s_axis_tuser),
    .wr_first       (wr_first),
    .wr_second      (wr_second),
    .wr_addr        (wr_addr),
    .outer_addr     (outer_addr),
    .inner_addr     (inner_addr),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_distance   (distance),
    .out_empty      (empty_set),
    .out_overflowed (overflowed)
  );

  // The datapath holds the points and does all arithmetic.
  hd3d_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS), .AW(AW)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .wr_first   (wr_first),
    .wr_second  (wr_second),
    .wr_addr    (wr_addr),
    .wr_point   (s_axis_tdata[3*COORD_BITS-1:0]),
    .outer_addr (outer_addr),
    .inner_addr (inner_addr),
    .cmd        (cmd),
    .status     (status)
  );

  assign m_axis_tdata = OUT_DW'(distance);
  assign m_axis_tuser = {overflowed, empty_set};

  // The square root must not start before the last pair has left the pipeline.
  a_sqrt_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |-> !status.pipe_busy)
    else $error("square root started with pairs still in flight");

  // No point may be loaded while the sets are being scanned.
  a_no_load_during_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_valid |-> !s_axis_tready)
    else $error("input ready during pair scan");

  // The root result never coincides with an active scan.
  a_done_outside_scan: assert property (@(posedge clk) disable iff (rst)
    status.sqrt_done |-> !cmd.scan_valid && !status.pipe_busy)
    else $error("square root finished during scan");

  // An empty set always reports a zero distance.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("empty set result with nonzero distance");

endmodule

// ===== sim/hausdorff_distance_3d_top_tb.sv =====
// Self-checking testbench for the 3D Hausdorff distance block: directed table, then random point sets.
`timescale 1ns / 1ps

module hausdorff_distance_3d_top_tb;
  import hd3d_pkg::*;

  localparam int COORD_W = 24;
  localparam int MAX_PTS = 1024;
  localparam int IN_DW   = ((3 * COORD_W + 7) / 8) * 8;

  // The block consumes and ignores the fourth command code.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [COORD_W-1:0] CO_MIN  = 24'h800000;
  localparam logic [COORD_W-1:0] CO_MAX  = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] CO_ONES = 24'hFFFFFF;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } hd_point_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              empty;
    logic              ovf;
  } hd_result_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    int                 reps;
    bit                 rnd;
    bit                 typed;
    hd_result_t         res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_DW-1:0] s_axis_tdata  = '0;
  logic [1:0]       s_axis_tuser  = CMD_LOAD_FIRST;

  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  // Predictor state: the two point sets, their fill counts and the drop flag.
  hd_point_t  first_pts  [MAX_PTS];
  hd_point_t  second_pts [MAX_PTS];
  int         first_n    = 0;
  int         second_n   = 0;
  bit         drop_seen  = 1'b0;

  hd_result_t pending_results[$];
  stim_row_t  dir_rows[$];
  int         mismatches = 0;
  bit         no_idle    = 1'b0;

  hausdorff_distance_3d_top #(
    .MAX_POINTS (MAX_PTS),
    .COORD_BITS (COORD_W)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned sq_gap(hd_point_t p, hd_point_t q);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'($signed(p.x)) - longint'($signed(q.x));
    dy = longint'($signed(p.y)) - longint'($signed(q.y));
    dz = longint'($signed(p.z)) - longint'($signed(q.z));
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Largest nearest-neighbor squared distance from one set into the other.
  function automatic longint unsigned worst_nearest(bit from_second);
    longint unsigned worst;
    longint unsigned best;
    longint unsigned d;
    hd_point_t p;
    hd_point_t q;
    int na;
    int nb;
    na = from_second ? second_n : first_n;
    nb = from_second ? first_n : second_n;
    worst = 0;
    for (int i = 0; i < na; i++) begin
      p = from_second ? second_pts[i] : first_pts[i];
      best = '1;
      for (int j = 0; j < nb; j++) begin
        q = from_second ? first_pts[j] : second_pts[j];
        d = sq_gap(p, q);
        if (d < best) best = d;
      end
      if (best > worst) worst = best;
    end
    return worst;
  endfunction

  // Floor of the square root, found one result bit at a time from the top.
  function automatic logic [DIST_W-1:0] floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    int b;
    r = 0;
    for (b = DIST_W; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    if (r > DIST_MAX) r = DIST_MAX;
    return r[DIST_W-1:0];
  endfunction

  function automatic hd_result_t hausdorff_expect();
    hd_result_t r;
    longint unsigned fwd;
    longint unsigned bwd;
    r.ovf      = drop_seen;
    r.empty    = (first_n == 0) || (second_n == 0);
    r.distance = '0;
    if (!r.empty) begin
      fwd        = worst_nearest(1'b0);
      bwd        = worst_nearest(1'b1);
      r.distance = floor_root(fwd > bwd ? fwd : bwd);
    end
    return r;
  endfunction

  function automatic void add_load(logic [1:0] cmd, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                   int reps, bit rnd);
    stim_row_t row;
    row.cmd   = cmd;
    row.x     = x;
    row.y     = y;
    row.z     = z;
    row.reps  = reps;
    row.rnd   = rnd;
    row.typed = 1'b0;
    row.res   = '0;
    dir_rows.push_back(row);
  endfunction

  // A compute row; typed rows carry a result that is obvious from the loads before it.
  function automatic void add_compute(bit typed, logic [DIST_W-1:0] distance, bit empty,
                                      bit ovf);
    stim_row_t row;
    row.cmd          = CMD_COMPUTE;
    row.x            = COORD_W'($urandom());
    row.y            = COORD_W'($urandom());
    row.z            = COORD_W'($urandom());
    row.reps         = 1;
    row.rnd          = 1'b0;
    row.typed        = typed;
    row.res.distance = distance;
    row.res.empty    = empty;
    row.res.ovf      = ovf;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int style, logic [COORD_W-1:0] base);
    case (style)
      0: return COORD_W'($urandom());
      1: return base + COORD_W'($urandom_range(0, 16383)) - COORD_W'(8192);
      default: begin
        case ($urandom_range(0, 4))
          0: return CO_MIN;
          1: return CO_MAX;
          2: return '0;
          3: return CO_ONES;
          default: return COORD_W'($urandom());
        endcase
      end
    endcase
  endfunction

  // Drives one input transaction, waits for its acceptance and updates the predictor.
  task automatic send_item(input logic [1:0] cmd, input logic [COORD_W-1:0] px,
                           input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] pz,
                           input bit typed, input hd_result_t typed_res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {pz, py, px};
    do @(posedge clk); while (!s_axis_tready);
    case (cmd)
      CMD_LOAD_FIRST: begin
        if (first_n >= MAX_PTS) begin
          drop_seen = 1'b1;
        end else begin
          first_pts[first_n] = '{x: px, y: py, z: pz};
          first_n++;
        end
      end
      CMD_LOAD_SECOND: begin
        if (second_n >= MAX_PTS) begin
          drop_seen = 1'b1;
        end else begin
          second_pts[second_n] = '{x: px, y: py, z: pz};
          second_n++;
        end
      end
      CMD_COMPUTE: begin
        pending_results.push_back(typed ? typed_res : hausdorff_expect());
        first_n   = 0;
        second_n  = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Holds the input side idle until every outstanding result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Result receiver with random stalls between transactions.
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin : result_check
    hd_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        check_field("distance", want.distance, m_axis_tdata[DIST_W-1:0]);
        check_field("tdata fill", 0, m_axis_tdata[OUT_DW-1:DIST_W]);
        check_field("empty_set", want.empty, m_axis_tuser[0]);
        check_field("overflowed", want.ovf, m_axis_tuser[1]);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    hd_result_t none;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] bz;
    int items;
    int n1;
    int n2;
    int l1;
    int l2;
    int style;
    int r;

    none = '0;

    // Directed table: empty sets, a distance along one axis, identical points, extremes,
    // ignored commands and a set filled past capacity.
    add_compute(1'b1, 0, 1'b1, 1'b0);
    add_load(CMD_LOAD_FIRST, 0, 0, 0, 1, 1'b0);
    add_compute(1'b1, 0, 1'b1, 1'b0);
    add_load(CMD_LOAD_SECOND, 5, 6, 7, 1, 1'b0);
    add_compute(1'b1, 0, 1'b1, 1'b0);
    add_load(CMD_LOAD_FIRST, 0, 0, 0, 1, 1'b0);
    add_load(CMD_LOAD_SECOND, 4096, 0, 0, 1, 1'b0);
    add_compute(1'b1, 4096, 1'b0, 1'b0);
    add_load(CMD_LOAD_FIRST, 1, 2, 3, 1, 1'b0);
    add_load(CMD_LOAD_SECOND, 1, 2, 3, 1, 1'b0);
    add_compute(1'b1, 0, 1'b0, 1'b0);
    add_load(CMD_UNUSED, CO_ONES, CO_ONES, CO_ONES, 3, 1'b0);
    add_load(CMD_LOAD_FIRST, CO_MIN, CO_MIN, CO_MIN, 1, 1'b0);
    add_load(CMD_LOAD_SECOND, CO_MAX, CO_MAX, CO_MAX, 1, 1'b0);
    add_compute(1'b0, 0, 1'b0, 1'b0);
    add_load(CMD_LOAD_FIRST, CO_MAX, CO_MAX, CO_MAX, 1, 1'b0);
    add_load(CMD_LOAD_SECOND, CO_MIN, CO_MIN, CO_MIN, 1, 1'b0);
    add_load(CMD_LOAD_FIRST, 0, 0, 0, 1, 1'b0);
    add_load(CMD_LOAD_SECOND, CO_ONES, CO_ONES, CO_ONES, 1, 1'b0);
    add_compute(1'b0, 0, 1'b0, 1'b0);
    add_load(CMD_LOAD_SECOND, 0, 0, 0, 1, 1'b1);
    add_load(CMD_LOAD_FIRST, 0, 0, 0, MAX_PTS + 1, 1'b1);
    add_compute(1'b0, 0, 1'b0, 1'b0);
    add_load(CMD_UNUSED, 0, 0, 0, 1, 1'b1);
    add_compute(1'b1, 0, 1'b1, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      for (int rep = 0; rep < row.reps; rep++) begin
        cx = row.rnd ? COORD_W'($urandom()) : row.x;
        cy = row.rnd ? COORD_W'($urandom()) : row.y;
        cz = row.rnd ? COORD_W'($urandom()) : row.z;
        send_item(row.cmd, cx, cy, cz, row.typed, row.res);
      end
    end

    // Random part: each pass fills two small sets in mixed order and computes.
    items = 0;
    while (items < 200) begin
      r  = $urandom_range(0, 19);
      n1 = (r == 0) ? 0 : (r < 3) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      r  = $urandom_range(0, 19);
      n2 = (r == 0) ? 0 : (r < 3) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      no_idle = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 9);
      style = (r < 4) ? 0 : (r < 9) ? 1 : 2;
      bx = COORD_W'($urandom());
      by = COORD_W'($urandom());
      bz = COORD_W'($urandom());
      l1 = 0;
      l2 = 0;
      while (l1 < n1 || l2 < n2) begin
        cx = pick_coord(style, bx);
        cy = pick_coord(style, by);
        cz = pick_coord(style, bz);
        if ($urandom_range(0, 11) == 0) begin
          send_item(CMD_UNUSED, cx, cy, cz, 1'b0, none);
        end else if (l2 >= n2 || (l1 < n1 && $urandom_range(0, 1) == 0)) begin
          send_item(CMD_LOAD_FIRST, cx, cy, cz, 1'b0, none);
          l1++;
          items++;
        end else begin
          send_item(CMD_LOAD_SECOND, cx, cy, cz, 1'b0, none);
          l2++;
          items++;
        end
      end
      if ($urandom_range(0, 9) == 0) drain_results();
      send_item(CMD_COMPUTE, COORD_W'($urandom()), COORD_W'($urandom()),
                COORD_W'($urandom()), 1'b0, none);
      items++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
